/* rtl/aat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants for the box transform core
// Widths of the fixed-point data path and the lane bundles passed between
// pipeline stages.
// ----------------------------------------------------------------------------
package aat_pkg;

	// Width of every input and output coordinate (signed fixed point).
	localparam int DATA_W = 32;
	// Full-precision product of two coordinates.
	localparam int PROD_W = 2 * DATA_W;
	// Sum of three products without overflow.
	localparam int SUM_W = PROD_W + 1;
	// Local axes x, y and z.
	localparam int LANES = 3;
	// Default number of fraction bits.
	localparam int FRAC_BITS_DEF = 16;

	// Input beat layout: position of each field in s_tdata, in DATA_W units.
	localparam int ROW_POS = 0;
	localparam int SHIFT_POS = 3;
	localparam int LO_POS = 4;
	localparam int HI_POS = 7;
	localparam int IN_FIELDS = 10;

	typedef logic [LANES-1:0][DATA_W-1:0] vec3_t;
	typedef logic [LANES-1:0][PROD_W-1:0] prod3_t;

endpackage

/* rtl/aat_mul_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_mul_stage: first pipeline stage, corner products
// Forms row_j * lo_j and row_j * hi_j at full width for each local axis and
// registers them together with the translation.
// ----------------------------------------------------------------------------
module aat_mul_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  aat_pkg::vec3_t              row,
	input  aat_pkg::vec3_t              lo,
	input  aat_pkg::vec3_t              hi,
	input  logic [aat_pkg::DATA_W-1:0]  shift,
	output logic                        out_valid,
	input  logic                        out_ready,
	output aat_pkg::prod3_t             prod_lo,
	output aat_pkg::prod3_t             prod_hi,
	output logic [aat_pkg::DATA_W-1:0]  out_shift
);

	logic                       valid_s1;
	aat_pkg::prod3_t            prod_lo_s1;
	aat_pkg::prod3_t            prod_hi_s1;
	logic [aat_pkg::DATA_W-1:0] shift_s1;
	aat_pkg::prod3_t            prod_lo_d;
	aat_pkg::prod3_t            prod_hi_d;

	// The stage takes a beat when it is empty or its content moves on.
	assign in_ready = !valid_s1 || out_ready;

	// One signed multiplier pair per lane.
	always_comb begin
		for (int j = 0; j < aat_pkg::LANES; j++) begin
			prod_lo_d[j] = aat_pkg::PROD_W'($signed(row[j]) * $signed(lo[j]));
			prod_hi_d[j] = aat_pkg::PROD_W'($signed(row[j]) * $signed(hi[j]));
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Product registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_lo_s1 <= prod_lo_d;
			prod_hi_s1 <= prod_hi_d;
			shift_s1   <= shift;
		end
	end

	assign out_valid = valid_s1;
	assign prod_lo   = prod_lo_s1;
	assign prod_hi   = prod_hi_s1;
	assign out_shift = shift_s1;

endmodule

/* rtl/aat_sel_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_sel_stage: second pipeline stage, per-axis extremes
// Picks the smaller and the larger of the two corner products of each lane.
// ----------------------------------------------------------------------------
module aat_sel_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  aat_pkg::prod3_t             prod_lo,
	input  aat_pkg::prod3_t             prod_hi,
	input  logic [aat_pkg::DATA_W-1:0]  in_shift,
	output logic                        out_valid,
	input  logic                        out_ready,
	output aat_pkg::prod3_t             pmin,
	output aat_pkg::prod3_t             pmax,
	output logic [aat_pkg::DATA_W-1:0]  out_shift
);

	logic                       valid_s2;
	aat_pkg::prod3_t            pmin_s2;
	aat_pkg::prod3_t            pmax_s2;
	logic [aat_pkg::DATA_W-1:0] shift_s2;
	aat_pkg::prod3_t            pmin_d;
	aat_pkg::prod3_t            pmax_d;

	assign in_ready = !valid_s2 || out_ready;

	// One signed compare per lane steers both selections.
	always_comb begin
		for (int j = 0; j < aat_pkg::LANES; j++) begin
			if ($signed(prod_lo[j]) < $signed(prod_hi[j])) begin
				pmin_d[j] = prod_lo[j];
				pmax_d[j] = prod_hi[j];
			end else begin
				pmin_d[j] = prod_hi[j];
				pmax_d[j] = prod_lo[j];
			end
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Selected product registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pmin_s2  <= pmin_d;
			pmax_s2  <= pmax_d;
			shift_s2 <= in_shift;
		end
	end

	assign out_valid = valid_s2;
	assign pmin      = pmin_s2;
	assign pmax      = pmax_s2;
	assign out_shift = shift_s2;

`ifndef SYNTHESIS
	// Every lane leaves this stage ordered.
	a_lane_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($signed(pmin_s2[0]) <= $signed(pmax_s2[0])) &&
			($signed(pmin_s2[1]) <= $signed(pmax_s2[1])) &&
			($signed(pmin_s2[2]) <= $signed(pmax_s2[2])))
		else $error("selected lane minimum exceeds maximum");
`endif

endmodule

/* rtl/aat_sum_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_sum_stage: third pipeline stage, lane sums
// Adds the three selected products of each bound at full precision.
// ----------------------------------------------------------------------------
module aat_sum_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  aat_pkg::prod3_t             pmin,
	input  aat_pkg::prod3_t             pmax,
	input  logic [aat_pkg::DATA_W-1:0]  in_shift,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [aat_pkg::SUM_W-1:0]   sum_min,
	output logic [aat_pkg::SUM_W-1:0]   sum_max,
	output logic [aat_pkg::DATA_W-1:0]  out_shift
);

	logic                       valid_s3;
	logic [aat_pkg::SUM_W-1:0]  sum_min_s3;
	logic [aat_pkg::SUM_W-1:0]  sum_max_s3;
	logic [aat_pkg::DATA_W-1:0] shift_s3;
	logic [aat_pkg::SUM_W-1:0]  sum_min_d;
	logic [aat_pkg::SUM_W-1:0]  sum_max_d;

	assign in_ready = !valid_s3 || out_ready;

	// Three-operand adds on sign-extended products.
	always_comb begin
		sum_min_d = {pmin[0][aat_pkg::PROD_W-1], pmin[0]}
			+ {pmin[1][aat_pkg::PROD_W-1], pmin[1]}
			+ {pmin[2][aat_pkg::PROD_W-1], pmin[2]};
		sum_max_d = {pmax[0][aat_pkg::PROD_W-1], pmax[0]}
			+ {pmax[1][aat_pkg::PROD_W-1], pmax[1]}
			+ {pmax[2][aat_pkg::PROD_W-1], pmax[2]};
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Sum registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sum_min_s3 <= sum_min_d;
			sum_max_s3 <= sum_max_d;
			shift_s3   <= in_shift;
		end
	end

	assign out_valid = valid_s3;
	assign sum_min   = sum_min_s3;
	assign sum_max   = sum_max_s3;
	assign out_shift = shift_s3;

endmodule

/* rtl/aat_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_out_stage: fourth pipeline stage, scaling and saturation
// Drops the fraction bits of each sum (floor), adds the translation and
// clamps to the signed 32-bit range. Its register is the output register.
// ----------------------------------------------------------------------------
module aat_out_stage #(
	parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [aat_pkg::SUM_W-1:0]   sum_min,
	input  logic [aat_pkg::SUM_W-1:0]   sum_max,
	input  logic [aat_pkg::DATA_W-1:0]  in_shift,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [aat_pkg::DATA_W-1:0]  axis_min,
	output logic [aat_pkg::DATA_W-1:0]  axis_max
);

	localparam int SHR_W = aat_pkg::SUM_W - FRAC_BITS;
	localparam int RES_W = SHR_W + 1;
	localparam int EXT_W = RES_W - aat_pkg::DATA_W;

	logic                       valid_s4;
	logic [aat_pkg::DATA_W-1:0] axis_min_s4;
	logic [aat_pkg::DATA_W-1:0] axis_max_s4;
	logic [RES_W-1:0]           shift_ext;
	logic [RES_W-1:0]           res_min;
	logic [RES_W-1:0]           res_max;

	// Clamp a wide signed value into the output range.
	function automatic logic [aat_pkg::DATA_W-1:0] sat_out(input logic [RES_W-1:0] v);
		logic [EXT_W:0] top;
		logic           fits;
		top  = v[RES_W-1:aat_pkg::DATA_W-1];
		fits = (&top) || !(|top);
		if (fits) begin
			sat_out = v[aat_pkg::DATA_W-1:0];
		end else if (v[RES_W-1]) begin
			sat_out = {1'b1, {(aat_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(aat_pkg::DATA_W-1){1'b1}}};
		end
	endfunction

	assign in_ready = !valid_s4 || out_ready;

	// Floor shift is a part-select of the sum; the translation is added unscaled.
	always_comb begin
		shift_ext = {{EXT_W{in_shift[aat_pkg::DATA_W-1]}}, in_shift};
		res_min = {sum_min[aat_pkg::SUM_W-1], sum_min[aat_pkg::SUM_W-1:FRAC_BITS]} + shift_ext;
		res_max = {sum_max[aat_pkg::SUM_W-1], sum_max[aat_pkg::SUM_W-1:FRAC_BITS]} + shift_ext;
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	// Output data registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			axis_min_s4 <= sat_out(res_min);
			axis_max_s4 <= sat_out(res_max);
		end
	end

	assign out_valid = valid_s4;
	assign axis_min  = axis_min_s4;
	assign axis_max  = axis_max_s4;

`ifndef SYNTHESIS
	// Bounds stay ordered through scaling and clamping.
	a_bound_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ($signed(axis_min_s4) <= $signed(axis_max_s4)))
		else $error("axis minimum exceeds axis maximum");

	// A loaded beat is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s4)
		else $error("loaded output beat not presented");
`endif

endmodule

/* rtl/aabb_affine_transform_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_core: one world axis of a transformed bounding box
// Takes one matrix row plus the local box corners per beat and returns the
// least and greatest world coordinate on that axis (Arvo form, fixed point).
//
//   Channel  Dir  Beat content (lowest bits first)
//   s_*      in   row_x, row_y, row_z, row_shift, box_lo_x/y/z, box_hi_x/y/z
//   m_*      out  axis_min, axis_max
//
// A beat may enter every cycle while s_tready is high. It passes four register
// stages (multiply, select, sum, scale and clamp); the last one drives m_*.
// Each stage holds its beat while the next one is full, so stalls at m_tready
// back up stage by stage and s_tready falls only when all four are full.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module aabb_affine_transform_core #(
	parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row_x, row_y, row_z, row_shift, box_lo_x, box_lo_y, box_lo_z,
	// box_hi_x, box_hi_y, box_hi_z; 32 bits each from bit 0 up
	input  logic [aat_pkg::IN_FIELDS*aat_pkg::DATA_W-1:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// axis_min [31:0], axis_max [63:32]
	output logic [2*aat_pkg::DATA_W-1:0] m_tdata
);

	aat_pkg::vec3_t             row;
	aat_pkg::vec3_t             lo;
	aat_pkg::vec3_t             hi;
	logic [aat_pkg::DATA_W-1:0] row_shift;

	logic                       mul_valid, mul_ready;
	aat_pkg::prod3_t            mul_lo, mul_hi;
	logic [aat_pkg::DATA_W-1:0] mul_shift;

	logic                       sel_valid, sel_ready;
	aat_pkg::prod3_t            sel_min, sel_max;
	logic [aat_pkg::DATA_W-1:0] sel_shift;

	logic                       sum_valid, sum_ready;
	logic [aat_pkg::SUM_W-1:0]  sum_min, sum_max;
	logic [aat_pkg::DATA_W-1:0] sum_shift;

	logic [aat_pkg::DATA_W-1:0] axis_min, axis_max;

	// Unpack the input beat.
	always_comb begin
		for (int j = 0; j < aat_pkg::LANES; j++) begin
			row[j] = s_tdata[(aat_pkg::ROW_POS + j)*aat_pkg::DATA_W +: aat_pkg::DATA_W];
			lo[j]  = s_tdata[(aat_pkg::LO_POS + j)*aat_pkg::DATA_W +: aat_pkg::DATA_W];
			hi[j]  = s_tdata[(aat_pkg::HI_POS + j)*aat_pkg::DATA_W +: aat_pkg::DATA_W];
		end
		row_shift = s_tdata[aat_pkg::SHIFT_POS*aat_pkg::DATA_W +: aat_pkg::DATA_W];
	end

	aat_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.row       (row),
		.lo        (lo),
		.hi        (hi),
		.shift     (row_shift),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.prod_lo   (mul_lo),
		.prod_hi   (mul_hi),
		.out_shift (mul_shift)
	);

	aat_sel_stage u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.prod_lo   (mul_lo),
		.prod_hi   (mul_hi),
		.in_shift  (mul_shift),
		.out_valid (sel_valid),
		.out_ready (sel_ready),
		.pmin      (sel_min),
		.pmax      (sel_max),
		.out_shift (sel_shift)
	);

	aat_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sel_valid),
		.in_ready  (sel_ready),
		.pmin      (sel_min),
		.pmax      (sel_max),
		.in_shift  (sel_shift),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.sum_min   (sum_min),
		.sum_max   (sum_max),
		.out_shift (sum_shift)
	);

	aat_out_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.sum_min   (sum_min),
		.sum_max   (sum_max),
		.in_shift  (sum_shift),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.axis_min  (axis_min),
		.axis_max  (axis_max)
	);

	// Pack the output beat.
	assign m_tdata = {axis_max, axis_min};

`ifndef SYNTHESIS
	// A draining output leaves room all the way back to the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// An accepted input beat occupies the first stage next cycle.
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> mul_valid)
		else $error("accepted input beat lost at first stage");
`endif

endmodule
